[rtl/jad_pkg.sv]
package jad_pkg;

    // Register field width and counter default
    localparam int CFG_W               = 15;
    localparam int COUNTER_BITS_DEF    = 16;
    localparam int PADDR_W             = 4;
    localparam int PDATA_W             = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_READ_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_FIRST_REPEAT   = 2'd1;
    localparam logic [1:0] REG_REPEAT_DELAY   = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_DELAY = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] READ_INTERVAL_RST  = 15'd30;
    localparam logic [CFG_W-1:0] FIRST_REPEAT_RST   = 15'd400;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST   = 15'd200;
    localparam logic [CFG_W-1:0] DEBOUNCE_DELAY_RST = 15'd50;

    // Direction codes, already mirrored by 180 degrees
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } dir_t;

    // One result beat
    typedef struct packed {
        logic any_key;
        logic escape_press;
        logic previous_press;
        logic next_press;
        logic down_press;
        logic down_written;
        logic select_press;
    } result_t;

endpackage

[rtl/joystick_autorepeat_debounce_core.sv]
// Joystick auto-repeat with select debounce.
// Input channel (s_*): one beat per millisecond tick, carrying the five
// active-low pin levels and the main-menu flag. Result channel (m_*): exactly
// one beat per input beat, in order; m_any_key says whether any event fired.
// Every tick advances the three saturating elapsed counters; pins are only
// sampled once since_sample reaches read_interval. Directions fire on change
// and then auto-repeat; select fires on a debounced press.
// A result is registered; it appears in the cycle after its beat is accepted.
// Throughput: one beat per cycle unless m_ready stalls; the whole tick update
// is one combinational pass from the state registers into the result register.
// Stall: while the result register holds an untaken beat, a new input beat
// is still taken in the cycle that m_ready frees the register (s_ready =
// !m_valid || m_ready); otherwise input waits and state does not move.
// Reset (aresetn low, synchronous): registers return to their defaults
// (30, 400, 200, 50), counters clear, no direction held, select released,
// result register empty.
// APB: registers at byte 0x0, 0x4, 0x8, 0xC; pready is always high.
module joystick_autorepeat_debounce_core #(
    parameter int COUNTER_BITS = jad_pkg::COUNTER_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jad_pkg::PADDR_W-1:0]  paddr,
    input  logic [jad_pkg::PDATA_W-1:0]  pwdata,
    output logic [jad_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // tick input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_up_pin,
    input  logic                         s_down_pin,
    input  logic                         s_left_pin,
    input  logic                         s_right_pin,
    input  logic                         s_select_pin,
    input  logic                         s_main_menu,
    // event output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_any_key,
    output logic                         m_escape_press,
    output logic                         m_previous_press,
    output logic                         m_next_press,
    output logic                         m_down_press,
    output logic                         m_down_written,
    output logic                         m_select_press
);

    localparam int CW    = jad_pkg::CFG_W;
    localparam int CMP_W = (COUNTER_BITS > CW) ? COUNTER_BITS : CW;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    // configuration registers
    logic [CW-1:0] read_interval_reg;
    logic [CW-1:0] first_repeat_reg;
    logic [CW-1:0] repeat_delay_reg;
    logic [CW-1:0] debounce_delay_reg;

    // tick state
    logic [COUNTER_BITS-1:0] since_sample_reg, since_sample_next;
    logic [COUNTER_BITS-1:0] since_move_reg, since_move_next;
    logic [COUNTER_BITS-1:0] since_sel_reg, since_sel_next;
    jad_pkg::dir_t           held_dir_reg, held_dir_next;
    logic                    await_first_reg, await_first_next;
    logic                    prev_sel_reg, prev_sel_next;
    logic                    stable_sel_reg, stable_sel_next;

    // result register
    logic                    m_valid_reg;
    jad_pkg::result_t        result_reg, result_next;

    logic                    s_fire;
    logic                    cfg_wr;
    logic [1:0]              cfg_idx;

    logic [COUNTER_BITS-1:0] ss_inc, sm_inc, sc_inc;
    logic                    sample;
    jad_pkg::dir_t           dir;
    jad_pkg::dir_t           fired;
    logic                    sel_fired;
    logic [CW-1:0]           wait_ticks;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // APB: no wait states, registers indexed by word address
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            jad_pkg::REG_READ_INTERVAL:  prdata = jad_pkg::PDATA_W'(read_interval_reg);
            jad_pkg::REG_FIRST_REPEAT:   prdata = jad_pkg::PDATA_W'(first_repeat_reg);
            jad_pkg::REG_REPEAT_DELAY:   prdata = jad_pkg::PDATA_W'(repeat_delay_reg);
            jad_pkg::REG_DEBOUNCE_DELAY: prdata = jad_pkg::PDATA_W'(debounce_delay_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_interval_reg  <= jad_pkg::READ_INTERVAL_RST;
            first_repeat_reg   <= jad_pkg::FIRST_REPEAT_RST;
            repeat_delay_reg   <= jad_pkg::REPEAT_DELAY_RST;
            debounce_delay_reg <= jad_pkg::DEBOUNCE_DELAY_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                jad_pkg::REG_READ_INTERVAL:  read_interval_reg  <= pwdata[CW-1:0];
                jad_pkg::REG_FIRST_REPEAT:   first_repeat_reg   <= pwdata[CW-1:0];
                jad_pkg::REG_REPEAT_DELAY:   repeat_delay_reg   <= pwdata[CW-1:0];
                jad_pkg::REG_DEBOUNCE_DELAY: debounce_delay_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // saturating tick counters
    assign ss_inc = (since_sample_reg == CNT_MAX) ? CNT_MAX : since_sample_reg + 1'b1;
    assign sm_inc = (since_move_reg == CNT_MAX)   ? CNT_MAX : since_move_reg + 1'b1;
    assign sc_inc = (since_sel_reg == CNT_MAX)    ? CNT_MAX : since_sel_reg + 1'b1;

    assign sample = !(CMP_W'(ss_inc) < CMP_W'(read_interval_reg));

    // priority pick, mirrored: up pin gives DOWN, left pin gives RIGHT
    always_comb begin
        if (!s_up_pin)         dir = jad_pkg::DIR_DOWN;
        else if (!s_down_pin)  dir = jad_pkg::DIR_UP;
        else if (!s_left_pin)  dir = jad_pkg::DIR_RIGHT;
        else if (!s_right_pin) dir = jad_pkg::DIR_LEFT;
        else                   dir = jad_pkg::DIR_NONE;
    end

    assign wait_ticks = await_first_reg ? first_repeat_reg : repeat_delay_reg;

    // tick update
    always_comb begin
        since_sample_next = ss_inc;
        since_move_next   = sm_inc;
        since_sel_next    = sc_inc;
        held_dir_next     = held_dir_reg;
        await_first_next  = await_first_reg;
        prev_sel_next     = prev_sel_reg;
        stable_sel_next   = stable_sel_reg;
        fired             = jad_pkg::DIR_NONE;
        sel_fired         = 1'b0;
        if (sample) begin
            since_sample_next = '0;
            // direction: fire on change, then auto-repeat
            if (dir != held_dir_reg) begin
                held_dir_next    = dir;
                since_move_next  = '0;
                await_first_next = 1'b1;
                fired            = dir;
            end else if (dir != jad_pkg::DIR_NONE &&
                         CMP_W'(sm_inc) >= CMP_W'(wait_ticks)) begin
                fired            = dir;
                since_move_next  = '0;
                await_first_next = 1'b0;
            end
            // select debounce
            if (s_select_pin != prev_sel_reg) begin
                since_sel_next = '0;
            end
            if (CMP_W'(since_sel_next) > CMP_W'(debounce_delay_reg) &&
                s_select_pin != stable_sel_reg) begin
                stable_sel_next = s_select_pin;
                sel_fired       = !s_select_pin;
            end
            prev_sel_next = s_select_pin;
        end
    end

    // event mapping
    always_comb begin
        result_next = '0;
        if (fired != jad_pkg::DIR_NONE || sel_fired) begin
            result_next.any_key = 1'b1;
            if (s_main_menu) begin
                result_next.escape_press   = (fired == jad_pkg::DIR_DOWN);
                result_next.previous_press = (fired == jad_pkg::DIR_LEFT);
                result_next.next_press     = (fired == jad_pkg::DIR_RIGHT);
            end else begin
                result_next.escape_press   = (fired == jad_pkg::DIR_LEFT);
                result_next.previous_press = (fired == jad_pkg::DIR_UP);
                result_next.next_press     = (fired == jad_pkg::DIR_DOWN);
                result_next.down_press     = (fired == jad_pkg::DIR_RIGHT);
                result_next.down_written   = 1'b1;
            end
            result_next.select_press = sel_fired;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_sample_reg <= '0;
            since_move_reg   <= '0;
            since_sel_reg    <= '0;
            held_dir_reg     <= jad_pkg::DIR_NONE;
            await_first_reg  <= 1'b1;
            prev_sel_reg     <= 1'b1;
            stable_sel_reg   <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_fire) begin
                since_sample_reg <= since_sample_next;
                since_move_reg   <= since_move_next;
                since_sel_reg    <= since_sel_next;
                held_dir_reg     <= held_dir_next;
                await_first_reg  <= await_first_next;
                prev_sel_reg     <= prev_sel_next;
                stable_sel_reg   <= stable_sel_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_any_key        = result_reg.any_key;
    assign m_escape_press   = result_reg.escape_press;
    assign m_previous_press = result_reg.previous_press;
    assign m_next_press     = result_reg.next_press;
    assign m_down_press     = result_reg.down_press;
    assign m_down_written   = result_reg.down_written;
    assign m_select_press   = result_reg.select_press;

    // at most one mapped direction action per beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_escape_press, m_previous_press, m_next_press, m_down_press}))
        else $error("more than one direction action in a beat");

    // any action implies any_key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_escape_press || m_previous_press || m_next_press ||
                    m_down_press || m_down_written || m_select_press) |-> m_any_key)
        else $error("event without any_key");

    // state only moves on an accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(held_dir_reg) && $stable(stable_sel_reg))
        else $error("tick state changed without an input beat");

    // an empty result register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

[verif/joystick_autorepeat_debounce_core_tb.sv]
module joystick_autorepeat_debounce_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          LONG_HOLD   = 80;
    localparam int unsigned COUNT_MAX   = (1 << jad_pkg::COUNTER_BITS_DEF) - 1;

    // one tick beat, pins active low
    typedef struct packed {
        logic up_pin;
        logic down_pin;
        logic left_pin;
        logic right_pin;
        logic select_pin;
        logic main_menu;
    } pin_tick_t;

    // directed ticks, bit order {up, down, left, right, select, main_menu}
    localparam logic [5:0] DIRECTED_TICKS [21] = '{
        6'b111110, 6'b111110,             // all released
        6'b011110, 6'b011110,             // up press, then held repeat
        6'b101110, 6'b110110, 6'b111010,  // down, left, right
        6'b000010,                        // all four: up wins
        6'b100010,                        // up released: down wins
        6'b111110,
        6'b011111, 6'b101111,             // main menu up (escape), down (any_key only)
        6'b110111, 6'b111011,             // main menu left, right
        6'b111111,
        6'b111101, 6'b111101, 6'b111111,  // select press, hold, release in menu
        6'b111100, 6'b011100,             // select press, then up with it held
        6'b111110
    };

    // Predicts the event beat of each tick and checks result beats in order
    class key_event_tracker;
        logic [jad_pkg::CFG_W-1:0] read_interval;
        logic [jad_pkg::CFG_W-1:0] first_repeat_delay;
        logic [jad_pkg::CFG_W-1:0] repeat_delay;
        logic [jad_pkg::CFG_W-1:0] debounce_delay;
        int unsigned               since_sample;
        int unsigned               since_move;
        int unsigned               since_select_change;
        jad_pkg::dir_t             held;
        bit                        awaiting_first;
        bit                        prev_select;
        bit                        stable_select;
        jad_pkg::result_t          expected_events[$];
        string                     field_names[7];
        int                        errors;

        function new();
            read_interval       = jad_pkg::READ_INTERVAL_RST;
            first_repeat_delay  = jad_pkg::FIRST_REPEAT_RST;
            repeat_delay        = jad_pkg::REPEAT_DELAY_RST;
            debounce_delay      = jad_pkg::DEBOUNCE_DELAY_RST;
            since_sample        = 0;
            since_move          = 0;
            since_select_change = 0;
            held                = jad_pkg::DIR_NONE;
            awaiting_first      = 1'b1;
            prev_select         = 1'b1;
            stable_select       = 1'b1;
            errors              = 0;
            // indexed by bit position in result_t
            field_names = '{"select_press", "down_written", "down_press", "next_press",
                            "previous_press", "escape_press", "any_key"};
        endfunction

        function void write_reg(logic [1:0] idx, logic [jad_pkg::CFG_W-1:0] value);
            case (idx)
                jad_pkg::REG_READ_INTERVAL:  read_interval      = value;
                jad_pkg::REG_FIRST_REPEAT:   first_repeat_delay = value;
                jad_pkg::REG_REPEAT_DELAY:   repeat_delay       = value;
                jad_pkg::REG_DEBOUNCE_DELAY: debounce_delay     = value;
                default: ;
            endcase
        endfunction

        static function int unsigned bump(int unsigned v);
            return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
        endfunction

        function void note_tick(pin_tick_t t);
            jad_pkg::dir_t    seen;
            jad_pkg::dir_t    fired;
            bit               sel_fired;
            jad_pkg::result_t ev;
            fired     = jad_pkg::DIR_NONE;
            sel_fired = 1'b0;
            ev        = '0;

            since_sample        = bump(since_sample);
            since_move          = bump(since_move);
            since_select_change = bump(since_select_change);

            if (since_sample >= read_interval) begin
                since_sample = 0;
                // pins are mirrored 180 degrees, priority up, down, left, right
                if (!t.up_pin)         seen = jad_pkg::DIR_DOWN;
                else if (!t.down_pin)  seen = jad_pkg::DIR_UP;
                else if (!t.left_pin)  seen = jad_pkg::DIR_RIGHT;
                else if (!t.right_pin) seen = jad_pkg::DIR_LEFT;
                else                   seen = jad_pkg::DIR_NONE;

                if (seen != held) begin
                    held           = seen;
                    since_move     = 0;
                    awaiting_first = 1'b1;
                    fired          = seen;
                end else if (seen != jad_pkg::DIR_NONE && since_move >=
                             (awaiting_first ? first_repeat_delay : repeat_delay)) begin
                    fired          = seen;
                    since_move     = 0;
                    awaiting_first = 1'b0;
                end

                // select debounce: strict compare, so a fresh change never passes
                if (t.select_pin != prev_select)
                    since_select_change = 0;
                if (since_select_change > debounce_delay && t.select_pin != stable_select) begin
                    stable_select = t.select_pin;
                    sel_fired     = !t.select_pin;
                end
                prev_select = t.select_pin;
            end

            if (fired != jad_pkg::DIR_NONE || sel_fired) begin
                ev.any_key = 1'b1;
                if (t.main_menu) begin
                    ev.escape_press   = (fired == jad_pkg::DIR_DOWN);
                    ev.previous_press = (fired == jad_pkg::DIR_LEFT);
                    ev.next_press     = (fired == jad_pkg::DIR_RIGHT);
                end else begin
                    ev.escape_press   = (fired == jad_pkg::DIR_LEFT);
                    ev.previous_press = (fired == jad_pkg::DIR_UP);
                    ev.next_press     = (fired == jad_pkg::DIR_DOWN);
                    ev.down_press     = (fired == jad_pkg::DIR_RIGHT);
                    ev.down_written   = 1'b1;
                end
                ev.select_press = sel_fired;
            end
            expected_events.push_back(ev);
        endfunction

        function void check_event(jad_pkg::result_t got);
            jad_pkg::result_t want;
            int               b;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event beat, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            for (b = 0; b < $bits(jad_pkg::result_t); b++) begin
                if (got[b] !== want[b]) begin
                    $display("%0t: %s expected %b actual %b",
                             $time, field_names[b], want[b], got[b]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [jad_pkg::PADDR_W-1:0]   paddr;
    logic [jad_pkg::PDATA_W-1:0]   pwdata;
    logic [jad_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_up_pin;
    logic                          s_down_pin;
    logic                          s_left_pin;
    logic                          s_right_pin;
    logic                          s_select_pin;
    logic                          s_main_menu;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_any_key;
    logic                          m_escape_press;
    logic                          m_previous_press;
    logic                          m_next_press;
    logic                          m_down_press;
    logic                          m_down_written;
    logic                          m_select_press;

    key_event_tracker              tracker;
    bit                            steady_send;
    bit                            steady_take;
    bit                            long_hold_req;
    pin_tick_t                     cur_pins;
    int                            run_left;
    int unsigned                   cycle_count = 0;

    joystick_autorepeat_debounce_core u_dut (.*);

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle length: mostly none, some short, few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // held pin patterns of random length, some noise, some select bounce
    function automatic pin_tick_t next_tick(int hold_max);
        pin_tick_t t;
        if (run_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                cur_pins = pin_tick_t'(6'($urandom_range(0, 63)));
                run_left = $urandom_range(1, 3);
            end else begin
                {cur_pins.up_pin, cur_pins.down_pin, cur_pins.left_pin, cur_pins.right_pin}
                    = 4'b1111;
                case ($urandom_range(0, 5))
                    1: cur_pins.up_pin    = 1'b0;
                    2: cur_pins.down_pin  = 1'b0;
                    3: cur_pins.left_pin  = 1'b0;
                    4: cur_pins.right_pin = 1'b0;
                    5: {cur_pins.up_pin, cur_pins.down_pin, cur_pins.left_pin,
                        cur_pins.right_pin} = 4'($urandom_range(0, 15));
                    default: ;
                endcase
                if ($urandom_range(0, 2) == 0)
                    cur_pins.select_pin = !cur_pins.select_pin;
                if ($urandom_range(0, 3) == 0)
                    cur_pins.main_menu = !cur_pins.main_menu;
                run_left = $urandom_range(1, hold_max);
            end
        end
        run_left--;
        t = cur_pins;
        if ($urandom_range(0, 15) == 0)
            t.select_pin = !t.select_pin;
        return t;
    endfunction

    // offer one tick beat, valid stays high until taken
    task automatic send_tick(pin_tick_t t);
        int gap;
        gap = steady_send ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_up_pin, s_down_pin, s_left_pin, s_right_pin, s_select_pin, s_main_menu} <= t;
        do @(posedge aclk); while (!s_ready);
        tracker.note_tick(t);
    endtask

    task automatic random_ticks(int count, int hold_max);
        repeat (count) send_tick(next_tick(hold_max));
    endtask

    // stop sending and wait for every pending event beat
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.expected_events.size() != 0) @(posedge aclk);
    endtask

    // APB write with junk above the field, then read back
    task automatic reg_write(logic [1:0] idx, logic [jad_pkg::CFG_W-1:0] value);
        logic [jad_pkg::PDATA_W-1:0] word;
        word = $urandom();
        word[jad_pkg::CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[jad_pkg::CFG_W-1:0] !== value) begin
            $display("%0t: register %0d read expected %0d actual %0d",
                     $time, idx, value, prdata[jad_pkg::CFG_W-1:0]);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [jad_pkg::CFG_W-1:0] interval,
                              logic [jad_pkg::CFG_W-1:0] first_rep,
                              logic [jad_pkg::CFG_W-1:0] rep,
                              logic [jad_pkg::CFG_W-1:0] debounce);
        reg_write(jad_pkg::REG_READ_INTERVAL, interval);
        reg_write(jad_pkg::REG_FIRST_REPEAT, first_rep);
        reg_write(jad_pkg::REG_REPEAT_DELAY, rep);
        reg_write(jad_pkg::REG_DEBOUNCE_DELAY, debounce);
    endtask

    // result side: check taken beats, random and long stalls
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_event({m_any_key, m_escape_press, m_previous_press, m_next_press,
                                     m_down_press, m_down_written, m_select_press});
            if (hold == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && !steady_take) begin
                hold = gap_len();
            end
            m_ready <= (hold == 0);
            if (hold > 0) hold--;
        end
    end

    // stimulus
    initial begin
        int p;
        tracker       = new();
        steady_send   = 1'b0;
        steady_take   = 1'b0;
        long_hold_req = 1'b0;
        cur_pins      = '1;
        run_left      = 0;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        {s_up_pin, s_down_pin, s_left_pin, s_right_pin, s_select_pin, s_main_menu} <= 6'b111110;
        m_ready      <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: slow sampling, long repeat delays
        random_ticks(300, 200);
        drain();

        // directed ticks at minimum delays, sampled every tick
        set_config(15'd1, 15'd0, 15'd0, 15'd0);
        steady_send = 1'b1;
        foreach (DIRECTED_TICKS[i])
            send_tick(DIRECTED_TICKS[i]);
        drain();
        steady_send = 1'b0;

        // zero read interval samples on every tick
        set_config(15'd0, 15'd3, 15'd1, 15'd2);
        random_ticks(200, 12);
        drain();

        // long result stall while ticks keep coming
        set_config(15'd2, 15'd6, 15'd2, 15'd4);
        long_hold_req = 1'b1;
        random_ticks(300, 30);
        drain();

        // maximum delays: no repeats, select never accepted
        set_config(15'd1, 15'h7fff, 15'h7fff, 15'h7fff);
        random_ticks(60, 20);
        drain();

        // maximum interval: no sample in this phase
        set_config(15'h7fff, 15'd0, 15'd0, 15'd0);
        random_ticks(40, 10);
        drain();

        for (p = 0; p < 4; p++) begin
            steady_send = p[0];
            steady_take = p[1];
            set_config(15'($urandom_range(0, 4)), 15'($urandom_range(0, 12)),
                       15'($urandom_range(0, 6)), 15'($urandom_range(0, 8)));
            random_ticks(250, 25);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
